// ===== rtl/core/lfr_pkg.sv =====
// lfr_pkg: shared constants and command types for the lru frame replacer
// used by lfr_ctrl, lfr_datapath and lru_frame_replacer
`timescale 1ns / 1ps

package lfr_pkg;

    localparam int NUM_FRAMES_DEF = 64;
    localparam int CAP_W          = 7;
    localparam int ACT_W          = 2;
    localparam int FID_W          = 6;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [ACT_W-1:0] ACT_VICTIM = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PIN    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UNPIN  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NOP    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic rd_links;  // read links of target frame
        logic apply;     // unlink update
        logic done;      // push update and present result
    } lfr_cmd_t;

endpackage

// ===== rtl/core/lfr_ram.sv =====
// lfr_ram: generic single write, single read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/lfr_ctrl.sv =====
// lfr_ctrl: sequencing state machine for one request
// depends on lfr_pkg
`timescale 1ns / 1ps

module lfr_ctrl
    import lfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output lfr_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_READ;
            S_READ: state_next = S_WAIT;
            S_WAIT: state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign cmd.load     = (state_reg == S_IDLE) && start;
    assign cmd.rd_links = (state_reg == S_READ);
    assign cmd.apply    = (state_reg == S_WAIT);
    assign cmd.done     = (state_reg == S_DONE);

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.rd_links, cmd.apply, cmd.done}))
        else $error("overlapping commands");
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.rd_links ##1 cmd.apply ##1 cmd.done)
        else $error("bad sequence");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done |-> busy)
        else $error("done while idle");

endmodule

// ===== rtl/core/lfr_datapath.sv =====
// lfr_datapath: list links in ram, head/tail/count registers, result registers
// depends on lfr_pkg and lfr_ram
`timescale 1ns / 1ps

module lfr_datapath
    import lfr_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  lfr_cmd_t         cmd,
    input  logic [ACT_W-1:0] action,
    input  logic [FID_W-1:0] frame_num,
    input  logic [CAP_W-1:0] cap,
    output logic             victim_valid,
    output logic [FID_W-1:0] victim_frame,
    output logic             overflow_drop,
    output logic [CAP_W-1:0] tracked_count
);

    localparam int AW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);

    logic [NUM_FRAMES-1:0] in_list_reg;
    logic [AW-1:0]  newest_reg, oldest_reg;
    logic [CW-1:0]  count_reg;
    logic [AW-1:0]  frame_reg;
    logic           vv_reg, drop_reg;
    logic [FID_W-1:0] vf_reg;

    // decided at load
    logic           do_rm_reg, do_push_reg;
    logic [AW-1:0]  rm_reg;
    logic           ld_rm, ld_push, ld_vv, ld_drop;
    logic [AW-1:0]  ld_rm_frame;

    // link rams: read rm frame links
    logic           nw_we, od_we, nw_we2, od_we2;
    logic [AW-1:0]  nw_waddr, od_waddr;
    logic [AW-1:0]  nw_wdata, od_wdata;
    logic [AW-1:0]  nw_rdata, od_rdata;

    // second phase writes (push) done in done cycle
    logic [AW-1:0]  newest_mid, oldest_mid;
    logic [CW-1:0]  count_mid;

    logic           fid_ok;
    logic [AW-1:0]  fid;
    logic [CW-1:0]  cap_eff;
    logic           full;

    assign fid_ok = ({{(32-FID_W){1'b0}}, frame_num} < NUM_FRAMES);
    assign fid    = AW'(frame_num);
    assign cap_eff = (cap == '0) ? CW'(1) :
                     ({{(32-CAP_W){1'b0}}, cap} > NUM_FRAMES) ? CW'(NUM_FRAMES) : CW'(cap);
    assign full   = (count_reg >= cap_eff) && (count_reg != '0);

    // request decode at load
    always_comb
    begin
        ld_rm       = 1'b0;
        ld_push     = 1'b0;
        ld_vv       = 1'b0;
        ld_drop     = 1'b0;
        ld_rm_frame = fid;
        unique case (action)
            ACT_VICTIM:
            begin
                if (count_reg != '0)
                begin
                    ld_rm       = 1'b1;
                    ld_rm_frame = oldest_reg;
                    ld_vv       = 1'b1;
                end
            end
            ACT_PIN:
                ld_rm = fid_ok && in_list_reg[fid];
            ACT_UNPIN:
            begin
                if (fid_ok && !in_list_reg[fid])
                begin
                    ld_push = 1'b1;
                    if (full)
                    begin
                        ld_rm       = 1'b1;
                        ld_rm_frame = oldest_reg;
                        ld_vv       = 1'b1;
                        ld_drop     = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // unlink results computed combinationally in apply cycle
    always_comb
    begin
        newest_mid = newest_reg;
        oldest_mid = oldest_reg;
        count_mid  = count_reg;
        nw_we = 1'b0; od_we = 1'b0;
        nw_waddr = '0; od_waddr = '0; nw_wdata = '0; od_wdata = '0;
        if (cmd.apply && do_rm_reg)
        begin
            if (rm_reg == newest_reg) newest_mid = od_rdata;
            else
            begin
                od_we = 1'b1; od_waddr = nw_rdata; od_wdata = od_rdata;
            end
            if (rm_reg == oldest_reg) oldest_mid = nw_rdata;
            else
            begin
                nw_we = 1'b1; nw_waddr = od_rdata; nw_wdata = nw_rdata;
            end
            count_mid = count_reg - CW'(1);
            if (count_mid == '0)
            begin
                newest_mid = '0;
                oldest_mid = '0;
            end
        end
        nw_we2 = 1'b0; od_we2 = 1'b0;
        if (cmd.done && do_push_reg)
        begin
            od_we2 = (count_reg != '0);
            nw_we2 = (count_reg != '0);
        end
    end

    lfr_ram #(.WIDTH(AW), .DEPTH(NUM_FRAMES)) u_newer (
        .clk  (clk),
        .we   (nw_we | nw_we2),
        .waddr(nw_we2 ? newest_reg : nw_waddr),
        .wdata(nw_we2 ? frame_reg : nw_wdata),
        .raddr(rm_reg),
        .rdata(nw_rdata)
    );

    lfr_ram #(.WIDTH(AW), .DEPTH(NUM_FRAMES)) u_older (
        .clk  (clk),
        .we   (od_we | od_we2),
        .waddr(od_we2 ? frame_reg : od_waddr),
        .wdata(od_we2 ? newest_reg : od_wdata),
        .raddr(rm_reg),
        .rdata(od_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_list_reg  <= '0;
            newest_reg   <= '0;
            oldest_reg   <= '0;
            count_reg    <= '0;
            do_rm_reg    <= 1'b0;
            do_push_reg  <= 1'b0;
            victim_valid <= 1'b0;
            victim_frame <= '0;
            overflow_drop <= 1'b0;
            tracked_count <= '0;
            frame_reg <= '0;
            rm_reg <= '0;
            vv_reg <= 1'b0;
            drop_reg <= 1'b0;
            vf_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                frame_reg   <= fid;
                rm_reg      <= ld_rm_frame;
                do_rm_reg   <= ld_rm;
                do_push_reg <= ld_push;
                vv_reg      <= ld_vv;
                drop_reg    <= ld_drop;
                vf_reg      <= ld_vv ? FID_W'(oldest_reg) : '0;
            end
            if (cmd.apply)
            begin
                newest_reg <= newest_mid;
                oldest_reg <= oldest_mid;
                count_reg  <= count_mid;
                if (do_rm_reg) in_list_reg[rm_reg] <= 1'b0;
            end
            if (cmd.done)
            begin
                if (do_push_reg)
                begin
                    if (count_reg == '0) oldest_reg <= frame_reg;
                    newest_reg <= frame_reg;
                    in_list_reg[frame_reg] <= 1'b1;
                    count_reg <= count_reg + CW'(1);
                end
                victim_valid  <= vv_reg;
                victim_frame  <= vf_reg;
                overflow_drop <= drop_reg;
                tracked_count <= CAP_W'(count_reg + (do_push_reg ? CW'(1) : CW'(0)));
            end
            else
            begin
                victim_valid  <= 1'b0;
                overflow_drop <= 1'b0;
                victim_frame  <= '0;
            end
        end
    end

    a_drop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_drop |-> victim_valid)
        else $error("drop without victim");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NUM_FRAMES))
        else $error("count overrun");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (in_list_reg == '0))
        else $error("tracked bits set while empty");

endmodule

// ===== rtl/core/lru_frame_replacer.sv =====
// channel   | signals                                             | dir
// request   | start, busy, action, frame_num                      | in (busy: out)
// result    | done, victim_valid, victim_frame, overflow_drop,    | out
//           | tracked_count                                       |
// config    | cap_we, cap_wdata                                   | in
// each request steps through capture, link read, unlink, then push and result
// the registered read of the link ram sets the link read cycle
// busy is high from the cycle after start until the result word is shown
// done pulses for one cycle; the receiver cannot stall
// reset is asynchronous and clears the list; no clearing pass is needed
`timescale 1ns / 1ps

module lru_frame_replacer
    import lfr_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [ACT_W-1:0] action,
    input  logic [FID_W-1:0] frame_num,
    input  logic             cap_we,
    input  logic [CAP_W-1:0] cap_wdata,
    output logic             done,
    output logic             victim_valid,
    output logic [FID_W-1:0] victim_frame,
    output logic             overflow_drop,
    output logic [CAP_W-1:0] tracked_count
);

    logic [CAP_W-1:0] cap_reg;
    lfr_cmd_t         cmd;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAP_RESET;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cap_we) cap_reg <= cap_wdata;
            done_reg <= cmd.done;
        end
    end

    assign done = done_reg;

    lfr_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .cmd  (cmd)
    );

    lfr_datapath #(.NUM_FRAMES(NUM_FRAMES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (action),
        .frame_num    (frame_num),
        .cap          (cap_reg),
        .victim_valid (victim_valid),
        .victim_frame (victim_frame),
        .overflow_drop(overflow_drop),
        .tracked_count(tracked_count)
    );

endmodule
